/* src/pss_pkg.sv */
// Shared widths, codes and constants of the pointer speed scaler.
`default_nettype none
package pss_pkg;

  // Field and register widths.
  localparam int DELTA_WIDTH = 16;
  localparam int OUT_WIDTH   = 22;
  localparam int KIND_W      = 2;
  localparam int SPEED_W     = 10;
  localparam int STR_W       = 7;
  localparam int REM_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 28;
  localparam int PROD_W = 2 * MUL_W;

  // Speed and boost limits.
  localparam int PCT_UNITY    = 100;
  localparam int PCT_MIN      = 10;
  localparam int PCT_MAX      = 1000;
  localparam int STRENGTH_MAX = 100;
  localparam int BOOST_DIV    = 400;
  localparam int BOOST_CAP    = 400;
  // Square times strength at or above this value gives the capped boost.
  localparam int BOOST_LIMIT  = BOOST_DIV * BOOST_CAP;

  // Reciprocals of 25, rounded up, for floor division after a shift by 2 or 4.
  localparam int RECIP25_S17 = 5243;
  localparam int RECIP25_S22 = 167773;
  localparam int RECIP25_S32 = 171798692;

  // Event kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_REL_X = 2'd0,
    KIND_REL_Y = 2'd1,
    KIND_OTHER = 2'd2,
    KIND_ABS   = 2'd3
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED    = 2'd0,
    REG_ACCEL    = 2'd1,
    REG_STRENGTH = 2'd2
  } cfg_idx_t;

endpackage
`default_nettype wire

/* src/pointer_speed_scaler.sv */
// Pointer speed scaler: top level with sequencer, configuration and remainders.
// A pass-through word goes from idle to the done state and then the output register.
// A relative X or Y word runs check, scale, quotient, remainder, finish and done, after
// square, strength, boost and effective percent steps with acceleration; it skips to done
// from check at an effective percent of exactly 100. No word is taken until idle again.
// The next word is accepted while a finished result still waits in the output register.
// Reset (synchronous, rst high): speed 100, acceleration off, strength 50, remainders 0.
`default_nettype none
module pointer_speed_scaler (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration write port.
  input  wire logic                              cfg_we,
  input  wire logic [pss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pss_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Input stream.
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [15:0]                       s_tdata,  // [15:0] delta_in
  input  wire logic [pss_pkg::KIND_W-1:0]        s_tuser,  // [1:0] kind
  // Output stream.
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [23:0]                       m_tdata   // [21:0] delta_out, [23:22] zero
);
  import pss_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_SQ   = 12'b0000_0000_0010,
    ST_STR  = 12'b0000_0000_0100,
    ST_BDIV = 12'b0000_0000_1000,
    ST_EFF  = 12'b0000_0001_0000,
    ST_EDIV = 12'b0000_0010_0000,
    ST_CHK  = 12'b0000_0100_0000,
    ST_SCL  = 12'b0000_1000_0000,
    ST_QDIV = 12'b0001_0000_0000,
    ST_REM  = 12'b0010_0000_0000,
    ST_FIN  = 12'b0100_0000_0000,
    ST_DONE = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [SPEED_W-1:0] speed_percent;
  logic               accel_enable;
  logic [STR_W-1:0]   boost_strength;

  // Per-axis remainders.
  logic signed [REM_W-1:0] rem_x, rem_y;

  // Item registers.
  logic                          kind_y;
  logic signed [DELTA_WIDTH-1:0] delta;
  logic                          dneg;
  logic [DELTA_WIDTH:0]          spd;
  logic                          cap;
  logic                          sneg;
  logic [MUL_W-1:0]              smag;
  logic [OUT_WIDTH-2:0]          qmag;
  logic [OUT_WIDTH-1:0]          res;

  // Output register.
  logic                 out_valid;
  logic [OUT_WIDTH-1:0] out_data;

  // Shared multiplier.
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  pss_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Combinational helpers.
  logic                          accept;
  logic signed [DELTA_WIDTH:0]   din_ext;
  logic [DELTA_WIDTH:0]          din_mag;
  logic [OUT_WIDTH-1:0]          pass_val;
  logic                          sq_cap;
  logic [17:0]                   sq_clamped;
  logic [8:0]                    boost;
  logic [12:0]                   eff;
  logic signed [29:0]            prod_s;
  logic signed [29:0]            scaled;
  logic [MUL_W-1:0]              scaled_mag;
  logic [6:0]                    rem_mag;
  logic signed [REM_W-1:0]       rem_sel;
  logic signed [REM_W-1:0]       rem_new;
  logic [OUT_WIDTH-1:0]          q_ext;
  logic                          out_load;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_data};

  // Magnitude of the incoming delta and its pass-through form.
  assign din_ext  = {s_tdata[DELTA_WIDTH-1], s_tdata};
  assign din_mag  = s_tdata[DELTA_WIDTH-1] ? (DELTA_WIDTH+1)'(-din_ext)
                                           : (DELTA_WIDTH+1)'(din_ext);
  assign pass_val = OUT_WIDTH'(delta);

  // Boost and effective percent from the product of the previous step.
  assign sq_cap     = (prod >= PROD_W'(BOOST_LIMIT));
  assign sq_clamped = sq_cap ? 18'(BOOST_LIMIT) : prod[17:0];
  assign boost      = cap ? 9'(BOOST_CAP) : prod[25:17];
  assign eff        = accel_enable ? prod[34:22] : 13'(speed_percent);

  // Signed scaled value: delta times percent plus the carried remainder.
  assign rem_sel    = kind_y ? rem_y : rem_x;
  assign prod_s     = dneg ? -signed'({2'b00, prod[27:0]}) : signed'({2'b00, prod[27:0]});
  assign scaled     = prod_s + 30'(rem_sel);
  assign scaled_mag = scaled[29] ? MUL_W'(-scaled) : MUL_W'(scaled);

  // Remainder and quotient with the sign of the scaled value.
  assign rem_mag = 7'(smag - prod[MUL_W-1:0]);
  assign rem_new = sneg ? -signed'({1'b0, rem_mag}) : signed'({1'b0, rem_mag});
  assign q_ext   = sneg ? OUT_WIDTH'(-{1'b0, qmag}) : {1'b0, qmag};

  assign out_load = (state == ST_DONE) && (!out_valid || m_tready);

  // Multiplier operands for each step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SQ: begin
        mul_a = MUL_W'(spd);
        mul_b = MUL_W'(spd);
      end
      ST_STR: begin
        mul_a = MUL_W'(sq_clamped);
        mul_b = MUL_W'(boost_strength);
      end
      ST_BDIV: begin
        mul_a = MUL_W'(prod[17:4]);
        mul_b = MUL_W'(RECIP25_S17);
      end
      ST_EFF: begin
        mul_a = MUL_W'(speed_percent);
        mul_b = MUL_W'(10'(PCT_UNITY) + 10'(boost));
      end
      ST_EDIV: begin
        mul_a = MUL_W'(prod[18:2]);
        mul_b = MUL_W'(RECIP25_S22);
      end
      ST_CHK: begin
        mul_a = MUL_W'(spd);
        mul_b = MUL_W'(eff);
      end
      ST_QDIV: begin
        mul_a = MUL_W'(smag[MUL_W-1:2]);
        mul_b = MUL_W'(RECIP25_S32);
      end
      ST_REM: begin
        mul_a = MUL_W'(prod[52:32]);
        mul_b = MUL_W'(PCT_UNITY);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser[1]) begin
            state_next = ST_DONE;
          end else if (accel_enable) begin
            state_next = ST_SQ;
          end else begin
            state_next = ST_CHK;
          end
        end
      end
      ST_SQ:   state_next = ST_STR;
      ST_STR:  state_next = ST_BDIV;
      ST_BDIV: state_next = ST_EFF;
      ST_EFF:  state_next = ST_EDIV;
      ST_EDIV: state_next = ST_CHK;
      ST_CHK: begin
        if (eff == 13'(PCT_UNITY)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCL;
        end
      end
      ST_SCL:  state_next = ST_QDIV;
      ST_QDIV: state_next = ST_REM;
      ST_REM:  state_next = ST_FIN;
      ST_FIN:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state: sequencer, output valid, configuration and remainders.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      speed_percent  <= SPEED_W'(PCT_UNITY);
      accel_enable   <= 1'b0;
      boost_strength <= STR_W'(50);
      rem_x          <= '0;
      rem_y          <= '0;
    end else begin
      state <= state_next;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      // Register writes saturate into the legal ranges.
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SPEED: begin
            if (cfg_data < SPEED_W'(PCT_MIN)) begin
              speed_percent <= SPEED_W'(PCT_MIN);
            end else if (cfg_data > SPEED_W'(PCT_MAX)) begin
              speed_percent <= SPEED_W'(PCT_MAX);
            end else begin
              speed_percent <= cfg_data;
            end
          end
          REG_ACCEL: begin
            accel_enable <= cfg_data[0];
          end
          REG_STRENGTH: begin
            if (cfg_data[STR_W-1:0] > STR_W'(STRENGTH_MAX)) begin
              boost_strength <= STR_W'(STRENGTH_MAX);
            end else begin
              boost_strength <= cfg_data[STR_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end

      // The new remainder goes to the axis of the word.
      if (state == ST_FIN) begin
        if (kind_y) begin
          rem_y <= rem_new;
        end else begin
          rem_x <= rem_new;
        end
      end
    end
  end

  // Payload registers of the word in work.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_y <= (s_tuser == KIND_REL_Y);
      delta  <= s_tdata;
      dneg   <= s_tdata[DELTA_WIDTH-1];
      spd    <= din_mag;
    end
    if (state == ST_IDLE && accept) begin
      res <= OUT_WIDTH'(signed'(s_tdata));
    end
    if (state == ST_BDIV) begin
      cap <= sq_cap;
    end
    if (state == ST_CHK) begin
      res <= pass_val;
    end
    if (state == ST_SCL) begin
      sneg <= scaled[29];
      smag <= scaled_mag;
    end
    if (state == ST_REM) begin
      qmag <= prod[52:32];
    end
    if (state == ST_FIN) begin
      res <= q_ext;
    end
    if (out_load) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

/* src/pss_mul.sv */
// Shared unsigned multiplier with a registered product.
`default_nettype none
module pss_mul (
  input  wire logic                        clk,
  input  wire logic [pss_pkg::MUL_W-1:0]   a,
  input  wire logic [pss_pkg::MUL_W-1:0]   b,
  output logic      [pss_pkg::PROD_W-1:0]  prod
);
  import pss_pkg::*;

  // One product per cycle; the sequencer reads it in the following state.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule
`default_nettype wire

/* src/pss_checker.sv */
// Port-level checker for the pointer speed scaler and its bind statement.
`default_nettype none
module pss_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [15:0] s_tdata,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Only one word is in work at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("word accepted while busy");

  // A pass-through word reaches the free output unchanged, sign-extended to 22 bits.
  a_pass: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[1] && !m_tvalid |-> ##2
      (m_tvalid && m_tdata[15:0] == $past(s_tdata, 2)
       && m_tdata[21:16] == {6{$past(s_tdata[15], 2)}}))
    else $error("pass-through word altered");

endmodule

bind pointer_speed_scaler pss_checker u_pss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

/* bench/pointer_speed_scaler_tb.sv */
// Self-checking testbench for the pointer speed scaler, with its own scaling predictor.
`timescale 1ns / 1ps
module pointer_speed_scaler_tb;
  import pss_pkg::*;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    kind_t             kind;
    logic signed [15:0] delta;
  } motion_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;        // [15:0] delta_in
  logic [KIND_W-1:0] s_tuser = '0;  // [1:0] kind
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;             // [21:0] delta_out, [23:22] zero

  pointer_speed_scaler dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Words waiting to be sent, and scaled deltas waiting to come out.
  motion_t pending_moves[$];
  logic signed [21:0] expected_deltas[$];
  int pushed_count = 0;
  int accepted_count = 0;
  int mismatches = 0;

  // Handshake flags from the last rising edge, read by the falling-edge processes.
  logic s_taken = 1'b0;
  logic m_taken = 1'b0;

  // Idling limits and long hold-off requests, set per phase.
  int tx_max_gap = 3;
  int rx_max_gap = 3;
  int tx_wait = 0;
  int rx_wait = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;

  // Predictor copy of the configuration and the per-axis carried fractions.
  int speed_pct;
  logic boost_bit;
  int strength;
  longint carry_x;
  longint carry_y;

  initial begin
    forever #5 clk = ~clk;
  end

  // Scales one movement word as the block should, updating the carried fraction.
  function automatic logic signed [21:0] scale_motion(input motion_t mv);
    longint d;
    longint spd;
    longint boost;
    longint pct;
    longint total;
    longint res;
    d = longint'($signed(mv.delta));
    res = d;
    if (mv.kind == KIND_REL_X || mv.kind == KIND_REL_Y) begin
      pct = longint'(speed_pct);
      if (boost_bit) begin
        spd = (d < 0) ? -d : d;
        boost = spd * spd * strength / BOOST_DIV;
        if (boost > BOOST_CAP) boost = BOOST_CAP;
        pct = pct * (PCT_UNITY + boost) / PCT_UNITY;
      end
      // A gain of exactly unity leaves the delta and the fraction alone.
      if (pct != PCT_UNITY) begin
        total = d * pct + ((mv.kind == KIND_REL_X) ? carry_x : carry_y);
        res = total / PCT_UNITY;
        if (mv.kind == KIND_REL_X) carry_x = total - res * PCT_UNITY;
        else carry_y = total - res * PCT_UNITY;
      end
    end
    if (res > 2097151) res = 2097151;
    if (res < -2097152) res = -2097152;
    return res[21:0];
  endfunction

  // Monitor: predicts each accepted word, checks each result and tracks register writes.
  always @(posedge clk) begin : monitor
    logic signed [21:0] want;
    motion_t mv;
    if (rst) begin
      speed_pct = PCT_UNITY;
      boost_bit = 1'b0;
      strength = 50;
      carry_x = 0;
      carry_y = 0;
      s_taken <= 1'b0;
      m_taken <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        mv.kind = kind_t'(s_tuser);
        mv.delta = s_tdata;
        expected_deltas.push_back(scale_motion(mv));
        accepted_count++;
      end
      if (m_tvalid && m_tready) begin
        if (expected_deltas.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d",
                   $time, $signed(m_tdata[21:0]));
          mismatches++;
        end else begin
          want = expected_deltas.pop_front();
          if (m_tdata !== {2'b00, want}) begin
            $display("%0t: delta_out mismatch, expected %0d, got %0d (tdata %h)",
                     $time, want, $signed(m_tdata[21:0]), m_tdata);
            mismatches++;
          end
        end
      end
      // Register writes land at this edge, after the word taken at the same edge.
      if (cfg_we) begin
        case (cfg_index)
          REG_SPEED: begin
            speed_pct = int'(cfg_data);
            if (speed_pct < PCT_MIN) speed_pct = PCT_MIN;
            if (speed_pct > PCT_MAX) speed_pct = PCT_MAX;
          end
          REG_ACCEL: boost_bit = cfg_data[0];
          REG_STRENGTH: begin
            strength = int'(cfg_data[6:0]);
            if (strength > STRENGTH_MAX) strength = STRENGTH_MAX;
          end
          default: ;
        endcase
      end
      s_taken <= s_tvalid && s_tready;
      m_taken <= m_tvalid && m_tready;
    end
  end

  // Driver: offers queued words, idling a random number of cycles after each.
  always @(negedge clk) begin : sender
    motion_t mv;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_wait <= 0;
    end else if (!s_tvalid || s_taken) begin
      if (tx_wait > 0) begin
        s_tvalid <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (pending_moves.size() != 0) begin
        mv = pending_moves.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= mv.delta;
        s_tuser <= mv.kind;
        tx_wait <= $urandom_range(0, tx_max_gap);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: may stall after each result, and holds off for a long stretch on request.
  always @(negedge clk) begin : receiver
    int n;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else if (m_taken) begin
      n = $urandom_range(0, rx_max_gap);
      if (n == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        rx_wait <= n - 1;
      end
    end else if (rx_wait > 0) begin
      m_tready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic push_move(input kind_t kind, input logic signed [15:0] delta);
    motion_t mv;
    mv.kind = kind;
    mv.delta = delta;
    pushed_count++;
    pending_moves.push_back(mv);
  endtask

  // Waits until every queued word has gone in and every result has come out.
  task automatic wait_idle();
    while (accepted_count != pushed_count || expected_deltas.size() != 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    kind_t kind;
    logic signed [15:0] delta;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: unity gain, so every word passes straight through.
    push_move(KIND_REL_X, 16'sh7FFF);
    push_move(KIND_REL_Y, 16'sh8000);
    push_move(KIND_OTHER, 16'sh8000);
    push_move(KIND_ABS, 16'sh7FFF);
    push_move(KIND_REL_X, 16'sd5);
    push_move(KIND_ABS, -16'sd1);
    wait_idle();

    // Speed below the minimum saturates to 10; fractions carry between words.
    write_reg(REG_SPEED, 10'd3);
    push_move(KIND_REL_X, 16'sd7);
    push_move(KIND_REL_X, 16'sd7);
    push_move(KIND_OTHER, 16'sd123);
    push_move(KIND_REL_X, -16'sd7);
    push_move(KIND_REL_Y, 16'sh8000);
    push_move(KIND_REL_Y, 16'sh7FFF);
    push_move(KIND_REL_X, 16'sd0);
    wait_idle();

    // Unknown index ignored, speed and strength saturate high, only bit 0 enables.
    write_reg(REG_NONE, 10'h3FF);
    write_reg(REG_SPEED, 10'h3FF);
    write_reg(REG_STRENGTH, 10'h07F);
    write_reg(REG_ACCEL, 10'h3FF);
    push_move(KIND_REL_X, 16'sd1);
    push_move(KIND_REL_X, -16'sd20);
    push_move(KIND_REL_Y, 16'sh7FFF);
    push_move(KIND_REL_Y, 16'sh8000);
    push_move(KIND_REL_X, 16'sd0);
    wait_idle();

    // Boost that lands the gain on exactly unity passes the word through.
    write_reg(REG_SPEED, 10'd100);
    write_reg(REG_STRENGTH, 10'd0);
    push_move(KIND_REL_X, 16'sh8000);
    push_move(KIND_REL_Y, 16'sd300);
    wait_idle();
    write_reg(REG_SPEED, 10'd50);
    write_reg(REG_STRENGTH, 10'd100);
    push_move(KIND_REL_X, 16'sd20);
    push_move(KIND_REL_Y, -16'sd20);
    wait_idle();
    write_reg(REG_ACCEL, 10'h002);

    // Random phases, each under its own settings and idling pattern.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          write_reg(REG_SPEED, 10'd1000);
          write_reg(REG_ACCEL, 10'd1);
          write_reg(REG_STRENGTH, 10'd100);
        end
        1: begin
          write_reg(REG_SPEED, 10'd10);
          write_reg(REG_ACCEL, 10'd0);
          write_reg(REG_STRENGTH, 10'd0);
        end
        2: begin
          write_reg(REG_SPEED, 10'd100);
          write_reg(REG_ACCEL, 10'd1);
          write_reg(REG_STRENGTH, 10'd1);
        end
        3: begin
          write_reg(REG_SPEED, 10'd10);
          write_reg(REG_ACCEL, 10'd1);
          write_reg(REG_STRENGTH, 10'd100);
        end
        default: begin
          write_reg(REG_SPEED, 10'($urandom_range(0, 1023)));
          write_reg(REG_ACCEL, 10'($urandom_range(0, 1023)));
          write_reg(REG_STRENGTH, 10'($urandom_range(0, 1023)));
        end
      endcase

      if (p == 0) begin
        tx_max_gap = 0;
        rx_max_gap = 0;
      end else if (p == 1) begin
        // Long receiver hold-off while the sender keeps the input busy.
        tx_max_gap = 0;
        rx_max_gap = 13;
        holds_asked++;
      end else begin
        tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 13;
        rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 13;
      end

      for (int i = 0; i < 250; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: kind = KIND_REL_X;
          4, 5, 6, 7: kind = KIND_REL_Y;
          8: kind = KIND_OTHER;
          default: kind = KIND_ABS;
        endcase
        case ($urandom_range(0, 3))
          0: delta = $signed(16'($urandom_range(0, 16))) - 16'sd8;
          1: delta = 16'($urandom);
          2: delta = $urandom_range(0, 1) ? $signed(16'($urandom_range(0, 400)))
                                          : -$signed(16'($urandom_range(0, 400)));
          default: delta = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        endcase
        push_move(kind, delta);
      end
      wait_idle();
    end

    if (mismatches == 0 && expected_deltas.size() == 0) begin
      $display("pointer_speed_scaler_tb OK");
    end else begin
      $display("pointer_speed_scaler_tb NOT OK");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin : watchdog
    #5000000;
    $display("pointer_speed_scaler_tb NOT OK");
    $finish;
  end

endmodule

/* sim.f */
src/pss_pkg.sv
src/pss_mul.sv
src/pointer_speed_scaler.sv
src/pss_checker.sv
bench/pointer_speed_scaler_tb.sv
